FILE: src/polyev_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the polynomial evaluator.
// No dependencies; every other file of the block imports this package.
package polyev_pkg;

    localparam int DATA_W     = 32;   // Q-format sample, coefficient and result width
    localparam int LIMB_W     = 32;   // lane width of the wide multiplier
    localparam int ORDER_W    = 3;
    localparam int COEF_COUNT = 7;
    localparam int COEF_SEL_W = 3;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [DATA_W-1:0] t_data;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd1;

    localparam t_data SAT_MAX = 32'h7FFF_FFFF;
    localparam t_data SAT_MIN = 32'h8000_0000;

endpackage

FILE: src/polyev_in_if.sv
`timescale 1ns / 1ps
// Sample channel of the polynomial evaluator: valid/ready plus sample_x.
// Depends on polyev_pkg.
interface polyev_in_if;
    import polyev_pkg::*;

    logic  valid;
    logic  ready;
    t_data sample_x;

    modport source (output valid, output sample_x, input ready);
    modport sink   (input valid, input sample_x, output ready);
endinterface

FILE: src/polyev_out_if.sv
`timescale 1ns / 1ps
// Result channel of the polynomial evaluator: valid/ready plus value_y, overflow.
// Depends on polyev_pkg.
interface polyev_out_if;
    import polyev_pkg::*;

    logic  valid;
    logic  ready;
    t_data value_y;
    logic  overflow;

    modport source (output valid, output value_y, output overflow, input ready);
    modport sink   (input valid, input value_y, input overflow, output ready);
endinterface

FILE: src/polyev_step.sv
`timescale 1ns / 1ps
// One Horner step, three stages: lane products, product merge, sign and term add.
// Depends on polyev_pkg.
module polyev_step #(
    parameter int ACC_W = 256,
    parameter int SHIFT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ACC_W-1:0]   i_acc,
    input  polyev_pkg::t_data  i_x,
    input  polyev_pkg::t_data  i_coef,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ACC_W-1:0]   o_acc,
    output polyev_pkg::t_data  o_x
);
    import polyev_pkg::*;

    localparam int LIMBS = ACC_W / LIMB_W;
    localparam int PP_W  = 2 * LIMB_W;

    logic              r_a_v, r_b_v, r_c_v;
    logic              en_a, en_b, en_c;
    logic [PP_W-1:0]   r_a_pp [LIMBS];
    t_data             r_a_x, r_b_x, r_c_x;
    logic [ACC_W-1:0]  r_b_sum, r_c_acc;
    logic [DATA_W-1:0] mag;
    logic [ACC_W+LIMB_W-1:0] ev, od;
    logic [ACC_W-1:0]  term;
    logic              neg;

    assign en_c    = !r_c_v || i_ready;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;
    assign o_valid = r_c_v;
    assign o_acc   = r_c_acc;
    assign o_x     = r_c_x;

    // acc * |x| is formed modulo 2^ACC_W and negated afterwards; exact, no wrap
    assign mag = i_x[DATA_W-1] ? (~i_x + 1'b1) : i_x;

    // even lanes and odd lanes do not overlap, so each set is a plain concatenation
    always_comb begin
        ev = '0;
        od = '0;
        for (int i = 0; i < LIMBS; i++) begin
            if (i % 2 == 0) begin
                ev[i*LIMB_W +: PP_W] = r_a_pp[i];
            end else begin
                od[i*LIMB_W +: PP_W] = r_a_pp[i];
            end
        end
    end

    assign term = {{(ACC_W-DATA_W){i_coef[DATA_W-1]}}, i_coef} << SHIFT;
    assign neg  = r_b_x[DATA_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_valid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            for (int i = 0; i < LIMBS; i++) begin
                r_a_pp[i] <= {{LIMB_W{1'b0}}, i_acc[i*LIMB_W +: LIMB_W]}
                           * {{LIMB_W{1'b0}}, mag};
            end
            r_a_x <= i_x;
        end
        if (en_b) begin
            r_b_sum <= ev[ACC_W-1:0] + od[ACC_W-1:0];
            r_b_x   <= r_a_x;
        end
        if (en_c) begin
            r_c_acc <= (r_b_sum ^ {ACC_W{neg}}) + term + ACC_W'(neg);
            r_c_x   <= r_b_x;
        end
    end

`ifndef SYNTHESIS
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v && en_b |=> r_b_v)
        else $error("step: item lost between product and merge stages");
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_v && !i_ready |=> r_c_v && $stable(r_c_acc))
        else $error("step: stalled accumulator changed");
`endif

endmodule

FILE: src/polyev_round.sv
`timescale 1ns / 1ps
// Final rounding (half up) and saturation to Q format, with the output register.
// Depends on polyev_pkg.
module polyev_round #(
    parameter int ACC_W = 256,
    parameter int SH    = 96
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ACC_W-1:0]   i_acc,
    output logic               o_valid,
    input  logic               i_ready,
    output polyev_pkg::t_data  o_value_y,
    output logic               o_overflow
);
    import polyev_pkg::*;

    localparam logic [ACC_W-1:0] HALF =
        (SH > 0) ? (ACC_W'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam int HI_W = ACC_W - SH - DATA_W + 1;

    logic             r_r_v, r_valid;
    logic             en_r, en_s;
    logic [ACC_W-1:0] r_r_acc;
    t_data            r_value_y;
    logic             r_overflow;
    logic [HI_W-1:0]  hi;
    logic             fits;
    t_data            n_value_y;

    assign en_s    = !r_valid || i_ready;
    assign en_r    = !r_r_v || en_s;
    assign o_ready = en_r;

    // fits when every bit above the result's sign equals that sign
    assign hi   = r_r_acc[ACC_W-1 -: HI_W];
    assign fits = (&hi) || !(|hi);
    assign n_value_y = fits ? t_data'(r_r_acc[SH +: DATA_W])
                     : (r_r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (en_r) begin
                r_r_v <= i_valid;
            end
            if (en_s) begin
                r_valid <= r_r_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_r) begin
            r_r_acc <= i_acc + HALF;
        end
        if (en_s) begin
            r_value_y  <= n_value_y;
            r_overflow <= !fits;
        end
    end

    assign o_valid    = r_valid;
    assign o_value_y  = r_value_y;
    assign o_overflow = r_overflow;

`ifndef SYNTHESIS
    a_round_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_overflow |-> (r_value_y == SAT_MAX || r_value_y == SAT_MIN))
        else $error("round: overflow flagged without a saturated value");
    a_round_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_v && en_s |=> r_valid)
        else $error("round: item lost before the output register");
`endif

endmodule

FILE: src/polynomial_evaluator.sv
`timescale 1ns / 1ps
// Polynomial evaluator y = sum c_i * x^i, Q format, top level.
// Depends on polyev_pkg, polyev_in_if, polyev_out_if, polyev_step, polyev_round.
//
// Usage:
//   i_in  : samples (sample_x, signed Q16.16 by default), valid/ready.
//   o_out : one result per sample, same order: value_y (rounded half up,
//           saturated) and overflow, set when value_y was clamped.
//   Config: i_cfg_we / i_cfg_idx / i_cfg_data. Index 0 is the order, 1..7
//           the coefficients c0..c6. Write only while no item is in flight.
//   Orders above MAX_ORDER act as MAX_ORDER.
// Timing:
//   Each Horner step has three stages (32x32 lane products, product merge,
//   sign and term add), followed by one rounding stage and the output register.
//   Throughput is one item per cycle while o_out.ready is high; every stage holds its own valid bit.
// Reset (synchronous, active low) empties the pipeline and clears the order
// and all coefficients. i_in.ready is low during reset.
// When the receiver stalls, the output register holds its item and earlier
// stages keep filling bubbles, so input is still taken until the pipe is full.
module polynomial_evaluator #(
    parameter int MAX_ORDER = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    polyev_in_if.sink                        i_in,
    polyev_out_if.source                     o_out,
    input  logic                             i_cfg_we,
    input  logic [polyev_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [polyev_pkg::DATA_W-1:0]    i_cfg_data
);
    import polyev_pkg::*;

    // scale 2^(FRAC_BITS*MAX_ORDER) for any order; leading unused coefficients are zero
    localparam int ACC_W = LIMB_W * (MAX_ORDER + 2);
    localparam int SH    = FRAC_BITS * MAX_ORDER;
    localparam logic [ORDER_W-1:0] MAX_ORD_C = ORDER_W'(MAX_ORDER);

    logic [ORDER_W-1:0] r_order;
    t_data              r_coef [COEF_COUNT];
    logic [ORDER_W-1:0] eff_order;
    t_data              coef_eff [MAX_ORDER+1];

    logic [ACC_W-1:0]   ch_acc [MAX_ORDER+1];
    t_data              ch_x   [MAX_ORDER+1];
    logic               ch_v   [MAX_ORDER+1];
    logic               ch_rdy [MAX_ORDER+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
            for (int i = 0; i < COEF_COUNT; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ORDER) begin
                r_order <= i_cfg_data[ORDER_W-1:0];
            end else begin
                r_coef[COEF_SEL_W'(i_cfg_idx - CFG_COEF_BASE)] <= i_cfg_data;
            end
        end
    end

    assign eff_order = (r_order > MAX_ORD_C) ? MAX_ORD_C : r_order;

    for (genvar k = 0; k <= MAX_ORDER; k++) begin : g_coef
        assign coef_eff[k] = (ORDER_W'(k) <= eff_order) ? r_coef[k] : '0;
    end

    assign ch_acc[0] = {{(ACC_W-DATA_W){coef_eff[MAX_ORDER][DATA_W-1]}},
                        coef_eff[MAX_ORDER]};
    assign ch_x[0]   = i_in.sample_x;
    assign ch_v[0]   = i_in.valid;
    assign i_in.ready = ch_rdy[0] && i_rst_n;

    for (genvar j = 1; j <= MAX_ORDER; j++) begin : g_step
        polyev_step #(
            .ACC_W (ACC_W),
            .SHIFT (FRAC_BITS * j)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ch_v[j-1]),
            .o_ready (ch_rdy[j-1]),
            .i_acc   (ch_acc[j-1]),
            .i_x     (ch_x[j-1]),
            .i_coef  (coef_eff[MAX_ORDER-j]),
            .o_valid (ch_v[j]),
            .i_ready (ch_rdy[j]),
            .o_acc   (ch_acc[j]),
            .o_x     (ch_x[j])
        );
    end

    polyev_round #(
        .ACC_W (ACC_W),
        .SH    (SH)
    ) u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (ch_v[MAX_ORDER]),
        .o_ready    (ch_rdy[MAX_ORDER]),
        .i_acc      (ch_acc[MAX_ORDER]),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_value_y  (o_out.value_y),
        .o_overflow (o_out.overflow)
    );

endmodule
